@@ hdl/pid_queue_with_keyed_removal_defines.svh @@
// Assertion macros for the PID queue with keyed removal.
// Included by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef PID_QUEUE_WITH_KEYED_REMOVAL_DEFINES_SVH
`define PID_QUEUE_WITH_KEYED_REMOVAL_DEFINES_SVH

// condition holds at every edge out of reset
`define PQKR_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PQKR_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PQKR_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/pqkr_pkg.sv @@
// Shared constants, codes and helpers for the PID queue with keyed removal.
// No dependencies; used by the interfaces, the top level and the bench.
`default_nettype none

package pqkr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 16;

  localparam int OP_W     = 2;
  localparam int IN_PID_W = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef logic [PID_BITS-1:0] pid_t;

  // port identifier -> internal width (truncate or zero-extend)
  function automatic pid_t pid_in(input logic [IN_PID_W-1:0] p);
    logic [PID_BITS+IN_PID_W-1:0] ext;
    ext = {{PID_BITS{1'b0}}, p};
    return ext[PID_BITS-1:0];
  endfunction

  // internal identifier -> port width
  function automatic logic [IN_PID_W-1:0] pid_out(input pid_t p);
    logic [PID_BITS+IN_PID_W-1:0] ext;
    ext = {{IN_PID_W{1'b0}}, p};
    return ext[IN_PID_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] occ_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+OCC_W-1:0] ext;
    ext = {{OCC_W{1'b0}}, c};
    return ext[OCC_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/pqkr_if.sv @@
// Valid/ready channel interfaces for request and result items.
// Depends on pqkr_pkg for field widths.
`default_nettype none

interface pqkr_in_if;
  logic                               valid;
  logic                               ready;
  logic [pqkr_pkg::OP_W-1:0]          operation;
  logic [pqkr_pkg::IN_PID_W-1:0]      pid;

  modport source (output valid, output operation, output pid, input ready);
  modport sink   (input valid, input operation, input pid, output ready);
endinterface

interface pqkr_out_if;
  logic                               valid;
  logic                               ready;
  logic [pqkr_pkg::STATUS_W-1:0]      status;
  logic [pqkr_pkg::IN_PID_W-1:0]      removed_pid;
  logic [pqkr_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output removed_pid, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input removed_pid, input occupancy,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/pqkr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pqkr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output      logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/pid_queue_with_keyed_removal.sv @@
// Top level: FIFO of process identifiers with push, pop/keyed removal and lookup.
// Depends on pqkr_pkg, pqkr_if, pqkr_ram and pid_queue_with_keyed_removal_defines.svh.
//
//   channel   dir   handshake                 payload
//   in_ch     in    valid/ready               operation, pid
//   out_ch    out   valid/ready               status, removed_pid, occupancy
//
// Push and unused codes go straight to S_DONE; the result loads there into the output
// register once it is free, and ready returns as it loads. Remove and contains scan in
// S_SCAN, one RAM read per cycle through a single comparator and compacting write pointer.
// A result held in the output register stalls the next one in S_DONE; no new item is
// accepted while it waits. rst_n is synchronous; the queue comes up empty, entries stay.
`default_nettype none
`include "pid_queue_with_keyed_removal_defines.svh"

module pid_queue_with_keyed_removal (
  input wire logic          clk,
  input wire logic          rst_n,
  pqkr_in_if.sink           in_ch,
  pqkr_out_if.source        out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam int CW = pqkr_pkg::CNT_W;
  localparam int AW = pqkr_pkg::ADDR_W;

  state_t                         state_r, state_nxt;
  logic [pqkr_pkg::OP_W-1:0]      op_r, op_nxt;
  pqkr_pkg::pid_t                 pid_r, pid_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CW-1:0]                  rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]                  d_idx_r, d_idx_nxt;
  logic                           d_valid_r, d_valid_nxt;
  logic [CW-1:0]                  w_r, w_nxt;
  logic                           hit_r, hit_nxt;
  pqkr_pkg::pid_t                 head_r, head_nxt;
  pqkr_pkg::status_t              res_status_r, res_status_nxt;
  pqkr_pkg::pid_t                 res_removed_r, res_removed_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [pqkr_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [pqkr_pkg::IN_PID_W-1:0]  out_removed_r, out_removed_nxt;
  logic [pqkr_pkg::OCC_W-1:0]     out_occ_r, out_occ_nxt;

  logic            in_fire;
  pqkr_pkg::pid_t  in_pid;
  logic            is_pop;
  logic            rd_active;
  logic            scan_end;
  logic            match;
  logic            drop;
  logic            push_ok;
  logic            scan_we;
  logic            out_free;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  pqkr_pkg::pid_t  ram_wdata;
  pqkr_pkg::pid_t  ram_rdata;

  pqkr_ram #(
    .WIDTH (pqkr_pkg::PID_BITS),
    .DEPTH (pqkr_pkg::QUEUE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign in_pid             = pqkr_pkg::pid_in(in_ch.pid);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.removed_pid = out_removed_r;
  assign out_ch.occupancy   = out_occ_r;

  assign is_pop    = (op_r == pqkr_pkg::OP_REMOVE) && (pid_r == '0);
  assign rd_active = (state_r == S_SCAN) && (rd_idx_r != count_r);
  assign scan_end  = (state_r == S_SCAN) && !rd_active && !d_valid_r;
  assign match     = (ram_rdata == pid_r);
  assign drop      = is_pop ? (d_idx_r == '0) : match;
  assign push_ok   = in_fire && (in_ch.operation == pqkr_pkg::OP_PUSH)
                     && (count_r != pqkr_pkg::CNT_MAX);
  assign scan_we   = d_valid_r && (op_r == pqkr_pkg::OP_REMOVE) && !drop;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign ram_we    = push_ok || scan_we;
  assign ram_waddr = push_ok ? count_r[AW-1:0] : w_r[AW-1:0];
  assign ram_wdata = push_ok ? in_pid : ram_rdata;

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    pid_nxt         = pid_r;
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    d_idx_nxt       = d_idx_r;
    d_valid_nxt     = 1'b0;
    w_nxt           = w_r;
    hit_nxt         = hit_r;
    head_nxt        = head_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_occ_nxt     = out_occ_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt          = in_ch.operation;
          pid_nxt         = in_pid;
          rd_idx_nxt      = '0;
          w_nxt           = '0;
          hit_nxt         = 1'b0;
          head_nxt        = '0;
          res_removed_nxt = '0;
          res_status_nxt  = pqkr_pkg::ST_MISS;
          case (in_ch.operation)
            pqkr_pkg::OP_PUSH: begin
              if (push_ok) begin
                count_nxt      = count_r + CW'(1);
                res_status_nxt = pqkr_pkg::ST_OK;
              end else begin
                res_status_nxt = pqkr_pkg::ST_FULL;
              end
              state_nxt = S_DONE;
            end
            pqkr_pkg::OP_REMOVE, pqkr_pkg::OP_CONTAINS: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_active) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        d_valid_nxt = rd_active;
        d_idx_nxt   = rd_idx_r;
        if (d_valid_r) begin
          if (op_r == pqkr_pkg::OP_CONTAINS) begin
            if (match) begin
              hit_nxt = 1'b1;
            end
          end else if (drop) begin
            hit_nxt = 1'b1;
            if (is_pop) begin
              head_nxt = ram_rdata;
            end
          end else begin
            w_nxt = w_r + CW'(1);
          end
        end
        if (scan_end) begin
          state_nxt = S_DONE;
          if (hit_r) begin
            res_status_nxt = pqkr_pkg::ST_OK;
            if (op_r == pqkr_pkg::OP_REMOVE) begin
              count_nxt       = w_r;
              res_removed_nxt = is_pop ? head_r : pid_r;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_removed_nxt = pqkr_pkg::pid_out(res_removed_r);
          out_occ_nxt     = pqkr_pkg::occ_out(count_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      d_valid_r   <= d_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    pid_r         <= pid_nxt;
    rd_idx_r      <= rd_idx_nxt;
    d_idx_r       <= d_idx_nxt;
    w_r           <= w_nxt;
    hit_r         <= hit_nxt;
    head_r        <= head_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  `PQKR_CHECK(a_count_max, count_r <= pqkr_pkg::CNT_MAX, "occupancy beyond queue depth")
  `PQKR_IMPLY(a_write_behind, scan_we, w_r <= d_idx_r, "compaction write ahead of read")
  `PQKR_IMPLY(a_grow_on_push, count_r > $past(count_r), $past(push_ok), "count grew without push")
  `PQKR_NEXT(a_result_load, (state_r == S_DONE) && out_free,
             out_valid_r && (state_r == S_IDLE), "result not loaded")

endmodule

`default_nettype wire

@@ tb/sv/tb_pid_queue_with_keyed_removal.sv @@
// Self-checking bench for the PID queue with keyed removal: push, head pop,
// keyed removal and lookup under random valid/ready idling on both channels.
// Depends on pqkr_pkg, pqkr_if and the pid_queue_with_keyed_removal RTL.
`default_nettype none

module tb_pid_queue_with_keyed_removal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pqkr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 30;
  localparam int ITEM_TARGET = 1850;

  typedef struct {
    logic [pqkr_pkg::OP_W-1:0]     op;
    logic [pqkr_pkg::IN_PID_W-1:0] pid;
  } pq_req_t;

  typedef struct {
    pqkr_pkg::status_t              status;
    logic [pqkr_pkg::IN_PID_W-1:0]  removed_pid;
    logic [pqkr_pkg::OCC_W-1:0]     occupancy;
  } pq_result_t;

  logic clk;
  logic rst_n;

  pqkr_in_if  in_ch();
  pqkr_out_if out_ch();

  pid_queue_with_keyed_removal u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pq_req_t          pending_ops[$];
  pq_result_t       predicted_results[$];
  pqkr_pkg::pid_t   held_pids[$];

  logic in_taken;
  logic calm;
  int   cycle_cnt;
  int   stall_cycles;
  int   errors;
  int   results_checked;
  int   n_push, n_full, n_remove, n_removed, n_query, n_found, n_unused, peak_occ;

  assign calm = (cycle_cnt >= 3000) && (cycle_cnt < 7000);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void queue_op(input logic [pqkr_pkg::OP_W-1:0] op,
                                   input logic [pqkr_pkg::IN_PID_W-1:0] pid);
    pq_req_t r;
    r.op = op;
    r.pid = pid;
    pending_ops.push_back(r);
  endfunction

  // Behavioral queue: applies one operation and returns the expected result.
  function automatic pq_result_t apply_queue_op(input logic [pqkr_pkg::OP_W-1:0] op,
                                                input logic [pqkr_pkg::IN_PID_W-1:0] pid);
    pq_result_t     res;
    pqkr_pkg::pid_t key;
    pqkr_pkg::pid_t kept[$];
    key = pqkr_pkg::pid_t'(pid);
    res.status = pqkr_pkg::ST_MISS;
    res.removed_pid = '0;
    case (op)
      pqkr_pkg::OP_PUSH: begin
        n_push++;
        if (held_pids.size() >= pqkr_pkg::QUEUE_DEPTH) begin
          res.status = pqkr_pkg::ST_FULL;
          n_full++;
        end else begin
          held_pids.push_back(key);
          res.status = pqkr_pkg::ST_OK;
        end
      end
      pqkr_pkg::OP_REMOVE: begin
        n_remove++;
        if (held_pids.size() == 0) begin
          res.status = pqkr_pkg::ST_MISS;
        end else if (key == '0) begin
          res.removed_pid = pqkr_pkg::IN_PID_W'(held_pids.pop_front());
          res.status = pqkr_pkg::ST_OK;
        end else begin
          foreach (held_pids[i]) begin
            if (held_pids[i] != key) kept.push_back(held_pids[i]);
          end
          if (kept.size() != held_pids.size()) begin
            held_pids = kept;
            res.removed_pid = pqkr_pkg::IN_PID_W'(key);
            res.status = pqkr_pkg::ST_OK;
          end
        end
        if (res.status == pqkr_pkg::ST_OK) n_removed++;
      end
      pqkr_pkg::OP_CONTAINS: begin
        n_query++;
        foreach (held_pids[i]) begin
          if (held_pids[i] == key) res.status = pqkr_pkg::ST_OK;
        end
        if (res.status == pqkr_pkg::ST_OK) n_found++;
      end
      default: begin
        n_unused++;
      end
    endcase
    res.occupancy = pqkr_pkg::OCC_W'(held_pids.size());
    if (held_pids.size() > peak_occ) peak_occ = held_pids.size();
    return res;
  endfunction

  // driver and ready generator
  always @(negedge clk) begin
    pq_req_t nxt;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
        nxt = pending_ops.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= nxt.op;
        in_ch.pid <= nxt.pid;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= calm || ($urandom_range(99) >= 6);
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    pq_result_t want;
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: status %0d removed_pid %h occupancy %0d",
                   $time, out_ch.status, out_ch.removed_pid, out_ch.occupancy);
        end else begin
          want = predicted_results.pop_front();
          results_checked++;
          if (out_ch.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_ch.status);
          end
          if (out_ch.removed_pid !== want.removed_pid) begin
            errors++;
            $display("%0t: removed_pid mismatch: expected %h actual %h",
                     $time, want.removed_pid, out_ch.removed_pid);
          end
          if (out_ch.occupancy !== want.occupancy) begin
            errors++;
            $display("%0t: occupancy mismatch: expected %0d actual %0d",
                     $time, want.occupancy, out_ch.occupancy);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(apply_queue_op(in_ch.operation, in_ch.pid));
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, predicted_results.size());
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [pqkr_pkg::IN_PID_W-1:0] fill_vals[16];
    pqkr_pkg::pid_t                pool[6];
    pqkr_pkg::pid_t                key;
    int                            burst;
    int                            mode;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = pqkr_pkg::OP_PUSH;
    in_ch.pid = '0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    cycle_cnt = 0;
    stall_cycles = 0;
    errors = 0;
    results_checked = 0;
    n_push = 0;
    n_full = 0;
    n_remove = 0;
    n_removed = 0;
    n_query = 0;
    n_found = 0;
    n_unused = 0;
    peak_occ = 0;

    // directed: empty-queue cases, fill to full, overflow, keyed and head removal
    queue_op(pqkr_pkg::OP_REMOVE, '0);
    queue_op(pqkr_pkg::OP_REMOVE, 16'h0005);
    queue_op(pqkr_pkg::OP_CONTAINS, '0);
    queue_op(OP_UNUSED, 16'hFFFF);
    fill_vals = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF, 16'h5555, 16'hAAAA,
                  16'hFFFF, 16'h1234, 16'h7FFF, 16'h0002, 16'hFFFE, 16'h00FF, 16'hFF00,
                  16'h0F0F, 16'hF0F0};
    foreach (fill_vals[i]) queue_op(pqkr_pkg::OP_PUSH, fill_vals[i]);
    queue_op(pqkr_pkg::OP_PUSH, 16'hC3C3);
    queue_op(OP_UNUSED, 16'h0000);
    queue_op(pqkr_pkg::OP_CONTAINS, 16'hFFFF);
    queue_op(pqkr_pkg::OP_CONTAINS, 16'hC3C3);
    queue_op(pqkr_pkg::OP_REMOVE, 16'hFFFF);
    queue_op(pqkr_pkg::OP_REMOVE, 16'hFFFF);
    queue_op(pqkr_pkg::OP_REMOVE, '0);

    // random bursts over a small key pool so duplicates and keyed hits are common
    foreach (pool[i]) pool[i] = pqkr_pkg::pid_t'($urandom);
    while (pending_ops.size() < ITEM_TARGET) begin
      pool[$urandom_range(5)] = pqkr_pkg::pid_t'($urandom);
      if ($urandom_range(9) == 0) pool[0] = '0;
      burst = $urandom_range(3, 20);
      mode = $urandom_range(99);
      for (int n = 0; n < burst; n++) begin
        key = pool[$urandom_range(5)];
        if (mode < 30) begin
          queue_op(pqkr_pkg::OP_PUSH, key);
        end else if (mode < 45) begin
          queue_op(pqkr_pkg::OP_REMOVE, '0);
        end else if (mode < 85) begin
          case ($urandom_range(3))
            0: queue_op(pqkr_pkg::OP_PUSH, key);
            1: queue_op(pqkr_pkg::OP_REMOVE, key);
            2: queue_op(pqkr_pkg::OP_CONTAINS, key);
            default: queue_op(pqkr_pkg::OP_CONTAINS, pqkr_pkg::IN_PID_W'($urandom));
          endcase
        end else begin
          queue_op(pqkr_pkg::OP_W'($urandom_range(3)),
                   ($urandom_range(7) == 0) ? '0 : pqkr_pkg::IN_PID_W'($urandom));
        end
      end
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_ch.valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pushes (%0d dropped full), %0d removes (%0d hit), %0d lookups",
             n_push, n_full, n_remove, n_removed, n_query);
    $display("%0d lookups found, %0d unused codes, peak occupancy %0d, %0d results checked",
             n_found, n_unused, peak_occ, results_checked);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
